@@ hw/rtl/mnhs_pkg.sv @@
// Package for the multipath next-hop selector: item, config and job types,
// strategy/status/kind codes, and the lookup2 mix step used by the front end.
// No dependencies.
package mnhs_pkg;

	localparam int MAX_HOPS  = 16;
	localparam int HOP_W     = 5;
	localparam int IDX_W     = 4;
	localparam int ST_W      = 2;
	localparam int STRAT_W   = 2;
	localparam int KIND_W    = 2;
	localparam int HASH_W    = 32;
	localparam int BYTES_W   = 16;
	localparam int MIX_LINES = 9;
	localparam int STEP_W    = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 32;

	localparam logic [HASH_W-1:0] GOLDEN = 32'h9e3779b9;
	localparam logic [BYTES_W-1:0] SMALL_LIMIT_RESET = 16'd128;

	localparam logic [STRAT_W-1:0] STRAT_UNSET = 2'd0;
	localparam logic [STRAT_W-1:0] STRAT_HASH  = 2'd1;
	localparam logic [STRAT_W-1:0] STRAT_RR    = 2'd2;

	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_NOROUTE = 2'd1;
	localparam logic [ST_W-1:0] ST_UNSET   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_STRATEGY    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SALT        = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SMALL_LIMIT = 2'd2;

	// what the back end has to do with a job
	localparam logic [KIND_W-1:0] K_FIXED = 2'd0;
	localparam logic [KIND_W-1:0] K_HASH  = 2'd1;
	localparam logic [KIND_W-1:0] K_ROT   = 2'd2;

	typedef struct packed {
		logic [HASH_W-1:0]  flow_key;
		logic [HASH_W-1:0]  path_key;
		logic [BYTES_W-1:0] packet_bytes;
		logic [HOP_W-1:0]   hop_count;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] hop_index;
		logic [ST_W-1:0]  status;
	} out_item_t;

	typedef struct packed {
		logic [STRAT_W-1:0] strategy;
		logic [HASH_W-1:0]  hash_salt;
		logic [BYTES_W-1:0] small_size_limit;
	} cfg_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ST_W-1:0]   status;
		logic [HOP_W-1:0]  hops;
		logic [HASH_W-1:0] hash;
	} job_t;

	typedef struct packed {
		logic [HASH_W-1:0] a;
		logic [HASH_W-1:0] b;
		logic [HASH_W-1:0] c;
	} mix_t;

	// One line of the lookup2 mix: two subtracts and a shifted xor.
	function automatic mix_t mix_line(input logic [STEP_W-1:0] step, input mix_t s);
		mix_t r;
		r = s;
		unique case (step)
			4'd0: r.a = (s.a - s.b - s.c) ^ (s.c >> 13);
			4'd1: r.b = (s.b - s.c - s.a) ^ (s.a << 8);
			4'd2: r.c = (s.c - s.a - s.b) ^ (s.b >> 13);
			4'd3: r.a = (s.a - s.b - s.c) ^ (s.c >> 12);
			4'd4: r.b = (s.b - s.c - s.a) ^ (s.a << 16);
			4'd5: r.c = (s.c - s.a - s.b) ^ (s.b >> 5);
			4'd6: r.a = (s.a - s.b - s.c) ^ (s.c >> 3);
			4'd7: r.b = (s.b - s.c - s.a) ^ (s.a << 10);
			4'd8: r.c = (s.c - s.a - s.b) ^ (s.b >> 15);
			default: r = s;
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/mnhs_front.sv @@
// Front end: accepts an item, classifies it and, when it needs a hash, runs the hash mix one line
// per cycle on a shared unit, then pushes a job to the queue.
// Depends on mnhs_pkg.
module mnhs_front import mnhs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_item,
	output logic     push_valid,
	input  logic     push_ready,
	output job_t     push_job
);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	mix_t              mix_q;
	logic [KIND_W-1:0] kind_q;
	logic [ST_W-1:0]   status_q;
	logic [HOP_W-1:0]  hops_q;

	logic [HOP_W-1:0]  hops_c;
	logic [KIND_W-1:0] kind_c;
	logic [ST_W-1:0]   status_c;
	logic              small_c;
	logic              done;
	logic              accept;

	always_comb begin
		hops_c   = (in_item.hop_count > HOP_W'(MAX_HOPS)) ? HOP_W'(MAX_HOPS) : in_item.hop_count;
		small_c  = in_item.packet_bytes < cfg.small_size_limit;
		kind_c   = K_FIXED;
		status_c = ST_OK;
		if (hops_c == '0) begin
			status_c = ST_NOROUTE;
		end else if (hops_c != HOP_W'(1)) begin
			case (cfg.strategy)
				STRAT_HASH: kind_c = K_HASH;
				STRAT_RR:   kind_c = small_c ? K_HASH : K_ROT;
				default:    status_c = ST_UNSET;
			endcase
		end
	end

	assign done       = step_q == STEP_W'(MIX_LINES);
	assign push_valid = busy_q && done;
	assign in_ready   = !busy_q || (done && push_ready);
	assign accept     = in_valid && in_ready;
	assign push_job   = '{kind: kind_q, status: status_q, hops: hops_q, hash: mix_q.c};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			// skip the mix when the hash is not needed
			step_q <= (kind_c == K_HASH) ? '0 : STEP_W'(MIX_LINES);
		end else if (push_valid && push_ready) begin
			busy_q <= 1'b0;
		end else if (busy_q && !done) begin
			step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mix_q    <= '{a: GOLDEN + in_item.flow_key, b: GOLDEN + cfg.hash_salt,
				c: in_item.path_key};
			kind_q   <= kind_c;
			status_q <= status_c;
			hops_q   <= hops_c;
		end else if (busy_q && !done) begin
			mix_q <= mix_line(step_q, mix_q);
		end
	end

`ifndef NO_ASSERTIONS
	a_mix_only_hash: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !done |-> kind_q == K_HASH)
		else $error("mix running for a job that needs no hash");
`endif

endmodule

@@ hw/rtl/mnhs_queue.sv @@
// Short job queue between front and back end, register based.
// Depends on mnhs_pkg.
module mnhs_queue import mnhs_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  job_t push_job,
	output logic pop_valid,
	input  logic pop_ready,
	output job_t pop_job
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_job    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

@@ hw/rtl/mnhs_back.sv @@
// Back end: pops jobs, reduces the hash of a hash job modulo the hop count eight bits per
// cycle, keeps the rotation counter and holds the output register.
// Depends on mnhs_pkg.
module mnhs_back import mnhs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      pop_valid,
	output logic      pop_ready,
	input  job_t      pop_job,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	localparam int DIG_PER_CYC = 8;
	localparam int MOD_CYC     = HASH_W / DIG_PER_CYC;
	localparam int MOD_CNT_W   = $clog2(MOD_CYC);

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_MOD  = 2'd1;
	localparam logic [1:0] B_OUT  = 2'd2;

	logic [1:0]           state_q;
	logic [HOP_W-1:0]     rot_q;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic [HOP_W-1:0]     hops_q;
	logic [HASH_W-1:0]    dvd_q;
	logic [IDX_W-1:0]     rem_q;
	logic [IDX_W-1:0]     idx_q;
	logic [ST_W-1:0]      status_q;
	logic                 out_valid_q;
	out_item_t            out_q;

	logic [HOP_W-1:0] rot_base;
	logic [IDX_W-1:0] rem_c;
	logic             pop;
	logic             load_out;

	assign pop_ready = state_q == B_IDLE;
	assign pop       = pop_valid && pop_ready;
	assign load_out  = (state_q == B_OUT) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// restart a stale counter before use
	assign rot_base = (rot_q >= pop_job.hops) ? '0 : rot_q;

	// restoring remainder, one dividend bit per step
	always_comb begin
		logic [HOP_W-1:0] r;
		r     = '0;
		rem_c = rem_q;
		for (int i = 0; i < DIG_PER_CYC; i++) begin
			r = {rem_c, dvd_q[HASH_W-1-i]};
			if (r >= hops_q) begin
				r = r - hops_q;
			end
			rem_c = r[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			rot_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (pop) begin
						case (pop_job.kind)
							K_HASH: begin
								state_q <= B_MOD;
								cnt_q   <= '0;
							end
							K_ROT: begin
								rot_q   <= rot_base + 1'b1;
								state_q <= B_OUT;
							end
							default: state_q <= B_OUT;
						endcase
					end
				end
				B_MOD: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == MOD_CNT_W'(MOD_CYC - 1)) begin
						state_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (load_out) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			hops_q   <= pop_job.hops;
			status_q <= pop_job.status;
			dvd_q    <= pop_job.hash;
			rem_q    <= '0;
			idx_q    <= (pop_job.kind == K_ROT) ? rot_base[IDX_W-1:0] : '0;
		end else if (state_q == B_MOD) begin
			dvd_q <= dvd_q << DIG_PER_CYC;
			rem_q <= rem_c;
			idx_q <= rem_c;
		end
		if (load_out) begin
			out_q <= '{hop_index: idx_q, status: status_q};
		end
	end

`ifndef NO_ASSERTIONS
	a_mod_hops: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_MOD |-> hops_q >= HOP_W'(2))
		else $error("modulo running with fewer than two hops");
	a_rot_range: assert property (@(posedge clk) disable iff (!arst_n)
		rot_q <= HOP_W'(MAX_HOPS))
		else $error("rotation counter beyond hop limit");
	a_err_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != ST_OK |-> out_q.hop_index == '0)
		else $error("nonzero index on an error result");
`endif

endmodule

@@ hw/rtl/multipath_next_hop_selector_core.sv @@
// Multipath next-hop selector, top level: config registers, front end, job queue, back end.
// Hashed items are paced by the shared mix unit, one line a cycle, in the front end;
// other items by the back end's pop/output sequence. The back end takes a new job only
// after it has loaded the last result into its output register.
// Reset (arst_n low) clears config to defaults, rotation counter, queue and valid flags.
// Depends on mnhs_pkg, mnhs_front, mnhs_queue, mnhs_back.
module multipath_next_hop_selector_core import mnhs_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_item
);

	cfg_t cfg_q;
	logic push_valid;
	logic push_ready;
	job_t push_job;
	logic pop_valid;
	logic pop_ready;
	job_t pop_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{strategy: STRAT_UNSET, hash_salt: '0,
				small_size_limit: SMALL_LIMIT_RESET};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STRATEGY:    cfg_q.strategy         <= cfg_wdata[STRAT_W-1:0];
				REG_SALT:        cfg_q.hash_salt        <= cfg_wdata[HASH_W-1:0];
				REG_SMALL_LIMIT: cfg_q.small_size_limit <= cfg_wdata[BYTES_W-1:0];
				default: ;
			endcase
		end
	end

	mnhs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	mnhs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	mnhs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule
